// ===== hw/rtl/spq_pkg.sv =====
// Shared types and codes for the stable priority queue with delete by id.
package spq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_POP     = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_QUERY   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CHK,
        S_INS_LAST,
        S_FND_RD,
        S_FND_CHK,
        S_SHF_RD,
        S_SHF_WR,
        S_HEAD_RD,
        S_OUT
    } t_state;

    localparam int IdW   = 16;
    localparam int PrioW = 3;
    localparam int EntW  = IdW + PrioW;

endpackage

// ===== hw/rtl/spq_mem.sv =====
// Entry memory: one write port and one read port with registered read data.
module spq_mem #(
    parameter int Depth = 16,
    parameter int AddrW = 4
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AddrW-1:0]          i_waddr,
    input  logic [spq_pkg::EntW-1:0]  i_wdata,
    input  logic [AddrW-1:0]          i_raddr,
    output logic [spq_pkg::EntW-1:0]  o_rdata
);
    import spq_pkg::*;

    logic [EntW-1:0] r_mem [Depth];
    logic [EntW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/stable_priority_queue_delete_by_id_core.sv =====
// Top level: sequencer that keeps a sorted priority queue in one memory.
//
// The queue holds up to CAPACITY entries in a memory, kept in order from the
// head at address 0. An operation is taken when start is high and busy is low,
// and busy stays high until the cycle in which its result is shown. Every
// operation gives exactly one result, marked by o_valid for one cycle; the
// receiver cannot stall it, so it must take each transfer as it comes. The
// time per operation is set by the single memory read port, which each step of
// a scan or shift goes through, with registered read data. A query, a
// rejected insert or any operation on an empty queue goes straight to the head
// read and the result. An insert walks from the tail toward its place, moving
// each lower-priority entry up one slot. A remove head shifts the rest of the
// queue down. A remove by id first scans from the head, then shifts like a
// remove head from the match. The memory needs no clearing after reset: only
// entries below the fill count are ever used.
module stable_priority_queue_delete_by_id_core #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_entry_id,
    input  logic [2:0]  i_entry_priority,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_head_id,
    output logic [2:0]  o_head_priority,
    output logic        o_is_empty,
    output logic [4:0]  o_fill_count
);
    import spq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    t_state              r_state, n_state;
    t_op                 r_op;
    logic [IdW-1:0]      r_id;
    logic [PrioW-1:0]    r_prio;
    logic [AW-1:0]       r_k, n_k;
    logic [CW-1:0]       r_count, n_count;
    t_status             r_status, n_status;

    logic                r_valid;
    t_status             r_out_status;
    logic [IdW-1:0]      r_out_id;
    logic [PrioW-1:0]    r_out_prio;
    logic                r_out_empty;
    logic [4:0]          r_out_count;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [EntW-1:0]     mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [EntW-1:0]     mem_rdata;

    logic [CW-1:0]       w_cm1;
    logic                w_full, w_empty, w_last, w_ge, w_hit, w_k0, w_accept;
    logic [IdW-1:0]      w_rid;
    logic [PrioW-1:0]    w_rprio;

    spq_mem #(.Depth(CAPACITY), .AddrW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign w_accept = start && (r_state == S_IDLE);
    assign w_cm1    = r_count - 1'b1;
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_empty  = (r_count == '0);
    assign w_last   = (r_k == w_cm1[AW-1:0]);
    assign w_k0     = (r_k == '0);
    assign w_rid    = mem_rdata[EntW-1:PrioW];
    assign w_rprio  = mem_rdata[PrioW-1:0];
    assign w_ge     = (w_rprio >= r_prio);
    assign w_hit    = (w_rid == r_id);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (t_op'(i_opcode))
                        OP_INSERT: n_state = (w_full || w_empty) ? S_HEAD_RD : S_INS_RD;
                        OP_POP:    n_state = w_empty ? S_HEAD_RD : S_SHF_RD;
                        OP_REMOVE: n_state = w_empty ? S_HEAD_RD : S_FND_RD;
                        OP_QUERY:  n_state = S_HEAD_RD;
                    endcase
                end
            end
            S_INS_RD:   n_state = S_INS_CHK;
            S_INS_CHK: begin
                if (w_ge) begin
                    n_state = S_HEAD_RD;
                end else if (w_k0) begin
                    n_state = S_INS_LAST;
                end else begin
                    n_state = S_INS_RD;
                end
            end
            S_INS_LAST: n_state = S_HEAD_RD;
            S_FND_RD:   n_state = S_FND_CHK;
            S_FND_CHK: begin
                if (w_hit) begin
                    n_state = S_SHF_RD;
                end else if (w_last) begin
                    n_state = S_HEAD_RD;
                end else begin
                    n_state = S_FND_RD;
                end
            end
            S_SHF_RD:   n_state = w_last ? S_HEAD_RD : S_SHF_WR;
            S_SHF_WR:   n_state = S_SHF_RD;
            S_HEAD_RD:  n_state = S_OUT;
            S_OUT:      n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Memory control, scan index, count and status.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_k + 1'b1;
        mem_wdata = mem_rdata;
        mem_raddr = r_k;
        n_k       = r_k;
        n_count   = r_count;
        n_status  = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_status = ST_DONE;
                    n_k      = '0;
                    unique case (t_op'(i_opcode))
                        OP_INSERT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else if (w_empty) begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = {i_entry_id, i_entry_priority};
                                n_count   = r_count + 1'b1;
                            end else begin
                                n_k = w_cm1[AW-1:0];
                            end
                        end
                        OP_POP, OP_REMOVE: begin
                            if (w_empty) begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        OP_QUERY: n_status = ST_DONE;
                    endcase
                end
            end
            S_INS_CHK: begin
                // The new entry lands just behind the nearest entry of equal or
                // higher priority; lower ones move one slot toward the tail.
                mem_we = 1'b1;
                if (w_ge) begin
                    mem_wdata = {r_id, r_prio};
                    n_count   = r_count + 1'b1;
                end else if (!w_k0) begin
                    n_k = r_k - 1'b1;
                end
            end
            S_INS_LAST: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = {r_id, r_prio};
                n_count   = r_count + 1'b1;
            end
            S_FND_CHK: begin
                if (!w_hit) begin
                    if (w_last) begin
                        n_status = ST_NOT_FOUND;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            S_SHF_RD: begin
                mem_raddr = r_k + 1'b1;
                if (w_last) begin
                    n_count = w_cm1;
                end
            end
            S_SHF_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_k;
                n_k       = r_k + 1'b1;
            end
            S_HEAD_RD: mem_raddr = '0;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_valid  <= 1'b0;
            r_k      <= '0;
            r_status <= ST_DONE;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_k      <= n_k;
            r_status <= n_status;
            r_valid  <= (r_state == S_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= t_op'(i_opcode);
            r_id   <= i_entry_id;
            r_prio <= i_entry_priority;
        end
        if (r_state == S_OUT) begin
            r_out_status <= r_status;
            r_out_empty  <= w_empty;
            r_out_count  <= 5'(r_count);
            r_out_id     <= w_empty ? '0 : w_rid;
            r_out_prio   <= w_empty ? '0 : w_rprio;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_out_status;
    assign o_head_id       = r_out_id;
    assign o_head_priority = r_out_prio;
    assign o_is_empty      = r_out_empty;
    assign o_fill_count    = r_out_count;

    // The latched opcode is kept so an assertion can check the running operation.
    logic w_op_insert;
    assign w_op_insert = (r_op == OP_INSERT);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count exceeds capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted operation did not raise busy");

    a_out_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> o_valid)
        else $error("result strobe missing");

    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_LAST) |-> w_op_insert)
        else $error("head insert step outside an insert");

    a_shift_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHF_RD && w_last) |=> (r_count == $past(w_cm1)))
        else $error("removal did not shrink the queue by one");

endmodule

// ===== bench/stable_priority_queue_delete_by_id_core_test.sv =====
// Self-checking testbench for the stable priority queue core with delete by id.
`timescale 1ns / 1ps

module stable_priority_queue_delete_by_id_core_test;
    import spq_pkg::*;

    localparam int Depth = 16;
    localparam int WatchdogLimit = 20000;

    typedef struct packed {
        t_op         op;
        logic [15:0] id;
        logic [2:0]  prio;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic [15:0] head_id;
        logic [2:0]  head_prio;
        logic        empty;
        logic [4:0]  count;
    } t_response;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_opcode = '0;
    logic [15:0] i_entry_id = '0;
    logic [2:0]  i_entry_priority = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_head_id;
    logic [2:0]  o_head_priority;
    logic        o_is_empty;
    logic [4:0]  o_fill_count;

    always #1 i_clk = ~i_clk;

    stable_priority_queue_delete_by_id_core #(.CAPACITY(Depth)) DUT (.*);

    // Shadow copy of the queue contents, head at index 0.
    logic [15:0] shadow_ids[Depth];
    logic [2:0]  shadow_prios[Depth];
    int          shadow_count = 0;

    t_request  pending_requests[$];
    t_response awaited_responses[$];
    int        error_count = 0;
    int        transfers_in = 0;
    int        transfers_out = 0;
    int        idle_cycles = 0;
    int        gap_left = 0;
    bit        stimulus_done = 1'b0;
    int        full_rejects = 0;
    int        miss_count = 0;

    // Remove the entry at position pos, closing the gap toward the head.
    function automatic void shadow_take_out(int pos);
        for (int k = pos; k + 1 < shadow_count; k++) begin
            shadow_ids[k] = shadow_ids[k + 1];
            shadow_prios[k] = shadow_prios[k + 1];
        end
        shadow_count--;
    endfunction

    // Apply one operation to the shadow queue and return the result it should give.
    function automatic t_response apply_operation(t_request req);
        t_response rsp;
        int pos;
        rsp.status = ST_DONE;
        case (req.op)
            OP_INSERT: begin
                if (shadow_count >= Depth) begin
                    rsp.status = ST_FULL;
                end else begin
                    pos = 0;
                    // Equal priorities keep arrival order, so skip them too.
                    while (pos < shadow_count && shadow_prios[pos] >= req.prio) pos++;
                    for (int k = shadow_count; k > pos; k--) begin
                        shadow_ids[k] = shadow_ids[k - 1];
                        shadow_prios[k] = shadow_prios[k - 1];
                    end
                    shadow_ids[pos] = req.id;
                    shadow_prios[pos] = req.prio;
                    shadow_count++;
                end
            end
            OP_POP: begin
                if (shadow_count == 0) rsp.status = ST_NOT_FOUND;
                else shadow_take_out(0);
            end
            OP_REMOVE: begin
                pos = 0;
                while (pos < shadow_count && shadow_ids[pos] != req.id) pos++;
                if (pos >= shadow_count) rsp.status = ST_NOT_FOUND;
                else shadow_take_out(pos);
            end
            default: ;
        endcase
        rsp.empty = (shadow_count == 0);
        rsp.head_id = rsp.empty ? 16'd0 : shadow_ids[0];
        rsp.head_prio = rsp.empty ? 3'd0 : shadow_prios[0];
        rsp.count = shadow_count[4:0];
        return rsp;
    endfunction

    // Mostly short gaps, a few long ones, and many zero-gap stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: present the next request once the previous one is taken and the gap has expired.
    // A transfer happens at an edge where start is high and busy is low.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                transfers_in++;
                awaited_responses.push_back(apply_operation(
                    t_request'({i_opcode, i_entry_id, i_entry_priority})));
                gap_left = pick_gap();
            end
            if ((start && !busy) || !start) begin
                if (gap_left == 0 && pending_requests.size() > 0) begin
                    t_request req;
                    req = pending_requests.pop_front();
                    start <= 1'b1;
                    i_opcode <= req.op;
                    i_entry_id <= req.id;
                    i_entry_priority <= req.prio;
                end else begin
                    if (gap_left > 0) gap_left--;
                    start <= 1'b0;
                    i_opcode <= 2'($urandom());
                    i_entry_id <= 16'($urandom());
                    i_entry_priority <= 3'($urandom());
                end
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                t_response got;
                t_response want;
                got = {t_status'(o_status), o_head_id, o_head_priority, o_is_empty,
                       o_fill_count};
                transfers_out++;
                if (awaited_responses.size() == 0) begin
                    $display("%0t: unexpected result, actual %p", $time, got);
                    error_count++;
                end else begin
                    want = awaited_responses.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, o_status);
                        error_count++;
                    end
                    if (got.head_id !== want.head_id) begin
                        $display("%0t: head_id expected %0h actual %0h", $time,
                                 want.head_id, got.head_id);
                        error_count++;
                    end
                    if (got.head_prio !== want.head_prio) begin
                        $display("%0t: head_priority expected %0d actual %0d", $time,
                                 want.head_prio, got.head_prio);
                        error_count++;
                    end
                    if (got.empty !== want.empty) begin
                        $display("%0t: is_empty expected %0b actual %0b", $time,
                                 want.empty, got.empty);
                        error_count++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: fill_count expected %0d actual %0d", $time,
                                 want.count, got.count);
                        error_count++;
                    end
                    if (want.status == ST_FULL) full_rejects++;
                    if (want.status == ST_NOT_FOUND) miss_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_request make_request(t_op op, logic [15:0] id, logic [2:0] prio);
        t_request req;
        req.op = op;
        req.id = id;
        req.prio = prio;
        return req;
    endfunction

    // Random ids drawn mostly from a small pool so removes by id often hit
    // and duplicates are common.
    function automatic logic [15:0] pick_id();
        if ($urandom_range(0, 3) == 0) return 16'($urandom());
        return 16'($urandom_range(0, 7)) ^ ($urandom_range(0, 1) ? 16'hFFF8 : 16'h0000);
    endfunction

    initial begin
        int kind;
        // Directed part: empty cases, extremes, stable order, duplicates, full.
        pending_requests.push_back(make_request(OP_QUERY, 16'h0000, 3'd0));
        pending_requests.push_back(make_request(OP_POP, 16'h0000, 3'd0));
        pending_requests.push_back(make_request(OP_REMOVE, 16'hFFFF, 3'd7));
        pending_requests.push_back(make_request(OP_INSERT, 16'hFFFF, 3'd0));
        pending_requests.push_back(make_request(OP_INSERT, 16'h0000, 3'd7));
        pending_requests.push_back(make_request(OP_INSERT, 16'h1234, 3'd7));
        pending_requests.push_back(make_request(OP_INSERT, 16'hFFFF, 3'd3));
        pending_requests.push_back(make_request(OP_REMOVE, 16'hFFFF, 3'd0));
        pending_requests.push_back(make_request(OP_REMOVE, 16'hABCD, 3'd0));
        pending_requests.push_back(make_request(OP_POP, 16'h0000, 3'd0));
        pending_requests.push_back(make_request(OP_QUERY, 16'h5555, 3'd5));
        for (int k = 0; k < 14; k++)
            pending_requests.push_back(make_request(OP_INSERT, 16'(k * 4681), 3'(k % 8)));
        // The queue now holds sixteen entries, so these inserts are rejected.
        pending_requests.push_back(make_request(OP_INSERT, 16'hAAAA, 3'd7));
        pending_requests.push_back(make_request(OP_INSERT, 16'h5555, 3'd0));
        for (int k = 0; k < 16; k++)
            pending_requests.push_back(make_request(OP_POP, 16'h0000, 3'd0));

        // Random part: phases that lean toward filling or toward draining.
        for (int k = 0; k < 750; k++) begin
            kind = $urandom_range(0, 99);
            if (((k / 60) % 2) == 0) kind = kind / 2;
            else kind = 30 + kind * 7 / 10;
            if (kind < 45)
                pending_requests.push_back(make_request(OP_INSERT, pick_id(),
                                                        3'($urandom())));
            else if (kind < 65)
                pending_requests.push_back(make_request(OP_POP, 16'($urandom()),
                                                        3'($urandom())));
            else if (kind < 90)
                pending_requests.push_back(make_request(OP_REMOVE, pick_id(),
                                                        3'($urandom())));
            else
                pending_requests.push_back(make_request(OP_QUERY, 16'($urandom()),
                                                        3'($urandom())));
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_requests.size() == 0 && !start);
        wait (awaited_responses.size() == 0);
        // Allow a stray result to show up after the last expected one.
        repeat (100) @(posedge i_clk);

        $display("Covered %0d operations and %0d results, including %0d rejected inserts",
                 transfers_in, transfers_out, full_rejects);
        $display("and %0d operations on an empty queue or a missing id.", miss_count);
        if (error_count == 0 && awaited_responses.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
